// ===== design/nfm_pkg.sv =====
// ----------------------------------------------------------------------------
// nfm_pkg
// shared types, codes and defaults for the paged nor flash model
// ----------------------------------------------------------------------------
package nfm_pkg;

    // default geometry
    localparam int DEF_NUM_PAGES  = 16;
    localparam int DEF_PAGE_BYTES = 256;

    // widest flash address over the parameter range (256 pages of 256 bytes)
    localparam int CMD_ADDR_W  = 16;
    localparam int FAIL_W      = 33;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    // operation codes
    localparam logic [1:0] MODE_ERASE   = 2'd0;
    localparam logic [1:0] MODE_PROGRAM = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;
    localparam logic [1:0] MODE_QUERY   = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_ARG    = 2'd1;
    localparam logic [1:0] STATUS_POWER_FAIL = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] page;
        logic [8:0] start_offset;
        logic [8:0] op_length;
        logic [8:0] byte_index;
        logic [7:0] data_byte;
    } nfm_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  read_data;
        logic [31:0] erase_count;
    } nfm_out_t;

    // classified request handed from front to back
    typedef struct packed {
        logic [1:0]            mode;
        logic                  ok;
        logic [7:0]            page;
        logic [CMD_ADDR_W-1:0] addr;
        logic [7:0]            data;
    } nfm_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } nfm_qstat_t;

endpackage

// ===== design/nfm_front.sv =====
// ----------------------------------------------------------------------------
// nfm_front
// accepts requests, checks arguments and forms the flash address
// ----------------------------------------------------------------------------
module nfm_front #(
    parameter int NUM_PAGES  = nfm_pkg::DEF_NUM_PAGES,
    parameter int PAGE_BYTES = nfm_pkg::DEF_PAGE_BYTES
) (
    input  logic                s_valid,
    output logic                s_ready,
    input  nfm_pkg::nfm_in_t    s_data,
    input  logic                init_busy,
    input  nfm_pkg::nfm_qstat_t q_stat,
    output logic                q_push,
    output nfm_pkg::nfm_cmd_t   q_cmd
);
    import nfm_pkg::*;

    logic        page_ok;
    logic        range_ok;
    logic        ok;
    logic [9:0]  span;
    logic [9:0]  offs;
    logic [16:0] base;
    logic [16:0] addr;

    assign s_ready = !q_stat.full && !init_busy;
    assign q_push  = s_valid && s_ready;

    always_comb begin
        page_ok  = {1'b0, s_data.page} < 9'(NUM_PAGES);
        span     = {1'b0, s_data.start_offset} + {1'b0, s_data.op_length};
        offs     = {1'b0, s_data.start_offset} + {1'b0, s_data.byte_index};
        range_ok = page_ok && (span <= 10'(PAGE_BYTES))
                   && (s_data.byte_index < s_data.op_length);
        ok       = (s_data.mode == MODE_ERASE || s_data.mode == MODE_QUERY) ?
                   page_ok : range_ok;
        base     = 17'(s_data.page) * 17'(PAGE_BYTES);
        // erase carries the page base, byte requests the byte address
        addr     = (s_data.mode == MODE_ERASE) ? base : base + 17'(offs);

        q_cmd.mode = s_data.mode;
        q_cmd.ok   = ok;
        q_cmd.page = s_data.page;
        q_cmd.addr = ok ? addr[CMD_ADDR_W-1:0] : '0;
        q_cmd.data = s_data.data_byte;
    end

endmodule

// ===== design/nfm_queue.sv =====
// ----------------------------------------------------------------------------
// nfm_queue
// short request queue between front and back
// ----------------------------------------------------------------------------
module nfm_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  nfm_pkg::nfm_cmd_t   push_cmd,
    input  logic                pop,
    output nfm_pkg::nfm_cmd_t   head,
    output nfm_pkg::nfm_qstat_t stat
);
    import nfm_pkg::*;

    nfm_cmd_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign head       = slot_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/nfm_back.sv =====
// ----------------------------------------------------------------------------
// nfm_back
// executes queued requests on the flash array and erase counters
// ----------------------------------------------------------------------------
module nfm_back #(
    parameter int NUM_PAGES  = nfm_pkg::DEF_NUM_PAGES,
    parameter int PAGE_BYTES = nfm_pkg::DEF_PAGE_BYTES
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic signed [32:0]        cfg_wdata,
    input  nfm_pkg::nfm_cmd_t         q_head,
    input  nfm_pkg::nfm_qstat_t       q_stat,
    output logic                      q_pop,
    output logic                      init_busy,
    output logic                      m_valid,
    input  logic                      m_ready,
    output nfm_pkg::nfm_out_t         m_data
);
    import nfm_pkg::*;

    localparam int TOTAL  = NUM_PAGES * PAGE_BYTES;
    localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int PG_W   = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int OFF_W  = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;

    localparam logic [1:0] S_INIT  = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_ERASE = 2'd3;

    logic [7:0]  flash_mem [TOTAL];
    logic [31:0] cnt_mem   [NUM_PAGES];

    logic [1:0]               state_reg, state_next;
    logic [ADDR_W-1:0]        init_cnt_reg, init_cnt_next;
    logic [OFF_W-1:0]         off_reg, off_next;
    nfm_cmd_t                 cmd_reg, cmd_next;
    logic signed [FAIL_W-1:0] fail_reg, fail_next;
    logic                     m_valid_reg, m_valid_next;
    nfm_out_t                 m_data_reg, m_data_next;
    logic [7:0]               rd_data_reg;
    logic [31:0]              cnt_rd_reg;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [7:0]        mem_wdata;
    logic              cnt_we;
    logic [PG_W-1:0]   cnt_waddr, cnt_raddr;
    logic [31:0]       cnt_wdata;

    assign init_busy = (state_reg == S_INIT);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        state_next    = state_reg;
        init_cnt_next = init_cnt_reg;
        off_next      = off_reg;
        cmd_next      = cmd_reg;
        fail_next     = fail_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = ERASED_BYTE;
        mem_re        = 1'b0;
        mem_raddr     = q_head.addr[ADDR_W-1:0];
        cnt_we        = 1'b0;
        cnt_waddr     = cmd_reg.page[PG_W-1:0];
        cnt_wdata     = '0;
        cnt_raddr     = q_head.ok ? q_head.page[PG_W-1:0] : '0;

        if (cfg_we) begin
            fail_next = cfg_wdata;
        end

        unique case (state_reg)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = init_cnt_reg;
                if ({1'b0, init_cnt_reg} < (ADDR_W + 1)'(NUM_PAGES)) begin
                    cnt_we    = 1'b1;
                    cnt_waddr = init_cnt_reg[PG_W-1:0];
                end
                if (init_cnt_reg == ADDR_W'(TOTAL - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    init_cnt_next = init_cnt_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (!q_stat.empty && (!m_valid_reg || m_ready)) begin
                    q_pop      = 1'b1;
                    mem_re     = 1'b1;
                    cmd_next   = q_head;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                m_valid_next = 1'b1;
                m_data_next  = '{status: STATUS_OK, read_data: '0, erase_count: '0};
                state_next   = S_IDLE;
                unique case (cmd_reg.mode)
                    MODE_ERASE: begin
                        if (!cmd_reg.ok) begin
                            m_data_next.status = STATUS_BAD_ARG;
                        end else begin
                            cnt_we     = 1'b1;
                            cnt_wdata  = cnt_rd_reg + 32'd1;
                            off_next   = '0;
                            state_next = S_ERASE;
                        end
                    end
                    MODE_PROGRAM: begin
                        if (!cmd_reg.ok) begin
                            m_data_next.status = STATUS_BAD_ARG;
                        end else if (fail_reg == '0) begin
                            m_data_next.status = STATUS_POWER_FAIL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = cmd_reg.addr[ADDR_W-1:0];
                            mem_wdata = rd_data_reg & cmd_reg.data;
                            if (!fail_reg[FAIL_W-1]) begin
                                fail_next = fail_reg - 33'sd1;
                            end
                        end
                    end
                    MODE_READ: begin
                        if (!cmd_reg.ok) begin
                            m_data_next.status = STATUS_BAD_ARG;
                        end else begin
                            m_data_next.read_data = rd_data_reg;
                        end
                    end
                    MODE_QUERY: begin
                        if (cmd_reg.ok) begin
                            m_data_next.erase_count = cnt_rd_reg;
                        end
                    end
                    default: begin
                        m_data_next.status = STATUS_BAD_ARG;
                    end
                endcase
            end
            S_ERASE: begin
                mem_we    = 1'b1;
                mem_waddr = cmd_reg.addr[ADDR_W-1:0] + ADDR_W'(off_reg);
                if (off_reg == OFF_W'(PAGE_BYTES - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    off_next = off_reg + 1'b1;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            init_cnt_reg <= '0;
            fail_reg     <= -33'sd1;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            init_cnt_reg <= init_cnt_next;
            fail_reg     <= fail_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        off_reg    <= off_next;
        cmd_reg    <= cmd_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            flash_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= flash_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (mem_re) begin
            cnt_rd_reg <= cnt_mem[cnt_raddr];
        end
    end

`ifndef SYNTHESIS
    a_exec_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC) |-> !m_valid_reg)
        else $error("result slot busy when request executes");

    a_no_pop_in_init: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INIT) |-> !q_pop)
        else $error("request taken during clearing pass");

    a_countdown_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (fail_reg == '0 && !cfg_we) |=> (fail_reg == '0))
        else $error("countdown left zero without a reload");

    a_fail_needs_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_valid_reg) && m_data_reg.status == STATUS_POWER_FAIL)
        |-> ($past(fail_reg) == '0))
        else $error("power fail reported with live countdown");
`endif

endmodule

// ===== design/nor_flash_model_with_fault_injection.sv =====
// ----------------------------------------------------------------------------
// nor_flash_model_with_fault_injection
// paged nor flash model with erase counters and a power-fail countdown
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  s_        in         s_valid / s_ready  nfm_in_t  (one byte of an operation)
//  m_        out        m_valid / m_ready  nfm_out_t (one result per request)
//  cfg_      in         cfg_we             fail_limit, 33-bit signed
//
//  program, read and query requests pass the idle and exec states of the back
//  sequencer: idle pops and reads the flash array port, exec writes and presents
//  the result; page erase follows exec with an erase state, one byte per cycle
//  after reset a clearing pass over NUM_PAGES * PAGE_BYTES bytes fills the array
//  with 0xFF and zeroes the erase counters; no request is taken meanwhile
//  the front keeps accepting into a two-deep queue while the back is busy or
//  the result register waits; after the clearing pass s_ready drops only when
//  that queue is full
//
module nor_flash_model_with_fault_injection #(
    parameter int NUM_PAGES  = nfm_pkg::DEF_NUM_PAGES,
    parameter int PAGE_BYTES = nfm_pkg::DEF_PAGE_BYTES
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_we,
    input  logic signed [32:0] cfg_wdata,
    // request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  nfm_pkg::nfm_in_t   s_data,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output nfm_pkg::nfm_out_t  m_data
);
    import nfm_pkg::*;

    // classified request path
    nfm_cmd_t   q_cmd;
    nfm_cmd_t   q_head;
    nfm_qstat_t q_stat;
    logic       q_push;
    logic       q_pop;
    // back is still sweeping the array after reset
    logic       init_busy;

    // argument checks and address forming
    nfm_front #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .init_busy (init_busy),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    // decouples the front from the back sequencer
    nfm_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    // flash array, erase counters, countdown and result register
    nfm_back #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_head    (q_head),
        .q_stat    (q_stat),
        .q_pop     (q_pop),
        .init_busy (init_busy),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== tb/sv/nfm_flash_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfm_flash_checker
// watches both channels of the nor flash model, keeps a shadow of the array,
// the erase counters and the power-fail countdown, and compares every result
// ----------------------------------------------------------------------------
module nfm_flash_checker
    import nfm_pkg::*;
#(
    parameter int NUM_PAGES  = DEF_NUM_PAGES,
    parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic signed [32:0] cfg_wdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  nfm_in_t            s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  nfm_out_t           m_data,
    output int                 fail_count,
    output int                 pending_count
);

    logic [7:0]         shadow_flash [NUM_PAGES*PAGE_BYTES];
    logic [31:0]        shadow_erases [NUM_PAGES];
    logic signed [32:0] shadow_countdown;
    nfm_out_t           due_results [$];

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic reset_shadow();
        for (int a = 0; a < NUM_PAGES*PAGE_BYTES; a++) shadow_flash[a] = ERASED_BYTE;
        for (int p = 0; p < NUM_PAGES; p++) shadow_erases[p] = '0;
        shadow_countdown = -33'sd1;
    endtask

    // works out the result of one request and updates the shadow state
    task automatic predict_flash_op(input nfm_in_t req, output nfm_out_t res);
        int unsigned page_n, start_n, len_n, idx_n, addr;
        bit          page_ok, range_ok;
        page_n   = req.page;
        start_n  = req.start_offset;
        len_n    = req.op_length;
        idx_n    = req.byte_index;
        res      = '0;
        page_ok  = page_n < NUM_PAGES;
        range_ok = page_ok && (start_n + len_n <= PAGE_BYTES) && (idx_n < len_n);
        addr     = page_n * PAGE_BYTES + start_n + idx_n;
        res.status = STATUS_OK;
        case (req.mode)
            MODE_ERASE: begin
                if (!page_ok) begin
                    res.status = STATUS_BAD_ARG;
                end else begin
                    for (int b = 0; b < PAGE_BYTES; b++)
                        shadow_flash[page_n*PAGE_BYTES + b] = ERASED_BYTE;
                    shadow_erases[page_n] = shadow_erases[page_n] + 32'd1;
                end
            end
            MODE_PROGRAM: begin
                if (!range_ok) begin
                    res.status = STATUS_BAD_ARG;
                end else if (shadow_countdown == 0) begin
                    res.status = STATUS_POWER_FAIL;
                end else begin
                    if (shadow_countdown > 0) shadow_countdown = shadow_countdown - 33'sd1;
                    shadow_flash[addr] = shadow_flash[addr] & req.data_byte;
                end
            end
            MODE_READ: begin
                if (!range_ok) res.status = STATUS_BAD_ARG;
                else res.read_data = shadow_flash[addr];
            end
            default: begin
                if (page_ok) res.erase_count = shadow_erases[page_n];
            end
        endcase
    endtask

    always @(posedge aclk) begin
        nfm_out_t want;
        if (!aresetn) begin
            reset_shadow();
            due_results.delete();
        end else begin
            if (cfg_we) shadow_countdown = cfg_wdata;
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf("result with nothing due (status %0d)",
                                              m_data.status));
                end else begin
                    want = due_results.pop_front();
                    if (m_data.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_data.status, want.status));
                    if (m_data.read_data !== want.read_data)
                        report_mismatch($sformatf("read_data %h, expected %h",
                                                  m_data.read_data, want.read_data));
                    if (m_data.erase_count !== want.erase_count)
                        report_mismatch($sformatf("erase_count %0d, expected %0d",
                                                  m_data.erase_count, want.erase_count));
                end
            end
            if (s_valid && s_ready) begin
                predict_flash_op(s_data, want);
                due_results.push_back(want);
            end
        end
        pending_count <= due_results.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives the nor flash model with directed and random requests under several
// idling patterns and fail_limit settings; a checker beside the block predicts
// and compares every result, this module only makes stimulus and the verdict
// ----------------------------------------------------------------------------
module testbench;
    import nfm_pkg::*;

    localparam int NUM_PAGES    = DEF_NUM_PAGES;
    localparam int PAGE_BYTES   = DEF_PAGE_BYTES;
    localparam int RANDOM_ITEMS = 1450;
    localparam int PHASES       = 6;
    localparam int LONG_HOLD    = 400;   // receiver hold-off, in cycles
    localparam int TAIL_CYCLES  = 300;   // a little over one page erase

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_kind_t;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic signed [32:0] cfg_wdata = '0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    nfm_in_t            s_data    = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    nfm_out_t           m_data;

    int fail_count;
    int pending_count;

    // idling odds, in percent
    int unsigned s_idle_pct  = 0;
    int unsigned m_stall_pct = 0;

    // long hold-off handshake between the stimulus and the receiver process
    int unsigned hold_kicks = 0;
    int unsigned hold_seen  = 0;
    int unsigned hold_left  = 0;

    always #5 aclk = ~aclk;

    nor_flash_model_with_fault_injection #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    nfm_flash_checker #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // result side: random stalls, plus the long hold-off when kicked
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_kicks != hold_seen) begin
            hold_seen <= hold_kicks;
            hold_left <= LONG_HOLD;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= m_stall_pct);
        end
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #50_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic nfm_in_t mk_req(input logic [1:0] mode, input int page,
                                       input int start, input int len,
                                       input int idx, input int data);
        nfm_in_t r;
        r.mode         = mode;
        r.page         = page[7:0];
        r.start_offset = start[8:0];
        r.op_length    = len[8:0];
        r.byte_index   = idx[8:0];
        r.data_byte    = data[7:0];
        return r;
    endfunction

    // offers one request and returns in the step of the edge that took it;
    // valid is left high so the next request can follow without a gap
    task automatic send_req(input nfm_in_t req);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop offering and wait until every result is back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    task automatic load_fail_limit(input logic signed [32:0] limit);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= limit;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_idling(input idle_kind_t kind);
        case (kind)
            IDLE_SENDER:   begin s_idle_pct = 70; m_stall_pct <= 0;  end
            IDLE_RECEIVER: begin s_idle_pct = 0;  m_stall_pct <= 70; end
            IDLE_BOTH:     begin s_idle_pct = 14; m_stall_pct <= 14; end
            default:       begin s_idle_pct = 0;  m_stall_pct <= 0;  end
        endcase
    endtask

    // one random operation: mostly well-formed byte sequences, some noise,
    // some truncated operations and stray indices
    task automatic random_op(inout int left);
        int         kind, page, len, start, cut, room;
        bit         broken;
        logic [1:0] mode;
        logic [63:0] raw;
        nfm_in_t    noise;
        kind = $urandom_range(99);
        if (kind < 8) begin
            // pure noise, every field at random
            raw   = {$urandom, $urandom};
            noise = raw[$bits(nfm_in_t)-1:0];
            send_req(noise);
            left--;
            return;
        end
        page = ($urandom_range(99) < 90) ? $urandom_range(NUM_PAGES-1) : $urandom_range(255);
        if (kind < 12)      mode = MODE_ERASE;
        else if (kind < 22) mode = MODE_QUERY;
        else if (kind < 62) mode = MODE_PROGRAM;
        else                mode = MODE_READ;
        if (mode == MODE_ERASE || mode == MODE_QUERY) begin
            // the other fields should make no difference here
            send_req(mk_req(mode, page, $urandom_range(511), $urandom_range(511),
                            $urandom_range(510), $urandom_range(255)));
            left--;
            return;
        end
        kind = $urandom_range(99);
        if (kind < 85)      len = $urandom_range(8, 1);
        else if (kind < 97) len = $urandom_range(32, 1);
        else                len = $urandom_range(PAGE_BYTES, 1);
        room = PAGE_BYTES - len;
        kind = $urandom_range(99);
        if (kind < 10)      start = $urandom_range(511);
        else if (kind < 55) start = $urandom_range((room < 31) ? room : 31, 0);
        else                start = $urandom_range(room, 0);
        broken = ($urandom_range(99) < 5);
        cut    = broken ? $urandom_range(len - 1) : len;
        for (int idx = 0; idx < cut && left > 0; idx++) begin
            send_req(mk_req(mode, page, start, len, idx, $urandom_range(255)));
            left--;
        end
        if (broken && left > 0) begin
            // an index past the end of the operation
            send_req(mk_req(mode, page, start, len, len + $urandom_range(510 - len),
                            $urandom_range(255)));
            left--;
        end
    endtask

    initial begin
        int                 left;
        logic signed [32:0] limit;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // countdown disabled for the first directed block
        load_fail_limit(-33'sd1);

        // read of a fresh byte, program with and-in, read back
        send_req(mk_req(MODE_READ,    0, 0, 1, 0, 8'h00));
        send_req(mk_req(MODE_PROGRAM, 0, 0, 4, 0, 8'hA5));
        send_req(mk_req(MODE_PROGRAM, 0, 0, 4, 1, 8'h3C));
        send_req(mk_req(MODE_PROGRAM, 0, 0, 4, 2, 8'hFF));
        send_req(mk_req(MODE_PROGRAM, 0, 0, 4, 3, 8'h00));
        send_req(mk_req(MODE_PROGRAM, 0, 0, 4, 0, 8'h0F));
        send_req(mk_req(MODE_READ,    0, 0, 4, 0, 8'h00));
        send_req(mk_req(MODE_READ,    0, 0, 4, 1, 8'h00));
        send_req(mk_req(MODE_QUERY,   0, 0, 0, 0, 8'h00));
        // erase ignores offset, length, index and data
        send_req(mk_req(MODE_ERASE,   0, 511, 511, 510, 8'hFF));
        send_req(mk_req(MODE_QUERY,   0, 0, 0, 0, 8'h00));
        send_req(mk_req(MODE_READ,    0, 0, 4, 1, 8'h00));
        // last page, last byte
        send_req(mk_req(MODE_ERASE,   NUM_PAGES-1, 0, 0, 0, 8'h00));
        send_req(mk_req(MODE_PROGRAM, NUM_PAGES-1, PAGE_BYTES-1, 1, 0, 8'h00));
        send_req(mk_req(MODE_READ,    NUM_PAGES-1, PAGE_BYTES-1, 1, 0, 8'h00));
        // bad page in every mode; a query of a bad page is ok with a zero count
        send_req(mk_req(MODE_ERASE,   NUM_PAGES, 0, 1, 0, 8'h00));
        send_req(mk_req(MODE_PROGRAM, 255, 0, 1, 0, 8'hAA));
        send_req(mk_req(MODE_READ,    NUM_PAGES, 0, 1, 0, 8'h00));
        send_req(mk_req(MODE_QUERY,   255, 0, 0, 0, 8'h00));
        // range past the page end
        send_req(mk_req(MODE_PROGRAM, 1, PAGE_BYTES-1, 2, 0, 8'h00));
        send_req(mk_req(MODE_READ,    1, 0, PAGE_BYTES+1, 0, 8'h00));
        // index outside the operation, zero length, widest fields
        send_req(mk_req(MODE_READ,    1, 0, 4, 4, 8'h00));
        send_req(mk_req(MODE_PROGRAM, 1, 0, 0, 0, 8'h00));
        send_req(mk_req(MODE_READ,    1, 511, 511, 510, 8'h00));

        // countdown of two: the third byte hits the power failure
        load_fail_limit(33'sd2);
        send_req(mk_req(MODE_PROGRAM, 2, 10, 3, 0, 8'h3C));
        send_req(mk_req(MODE_PROGRAM, 2, 10, 3, 1, 8'h0F));
        send_req(mk_req(MODE_PROGRAM, 2, 10, 3, 2, 8'h00));
        // argument checks win over an exhausted countdown
        send_req(mk_req(MODE_PROGRAM, 2, PAGE_BYTES-2, 3, 0, 8'h00));
        send_req(mk_req(MODE_READ,    2, 10, 3, 2, 8'h00));

        // countdown loaded with zero: no byte gets through, reads still work
        load_fail_limit(33'sd0);
        send_req(mk_req(MODE_PROGRAM, 3, 0, 1, 0, 8'h00));
        send_req(mk_req(MODE_READ,    3, 0, 1, 0, 8'h00));

        // random phases, each with its own idling and fail_limit
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       limit = {1'b0, 32'hFFFF_FFFF};
                1:       limit = 33'($urandom_range(60, 1));
                2:       limit = -33'sd1;
                3:       limit = 33'sd0;
                4:       limit = 33'($urandom_range(300, 1));
                default: limit = {1'b0, $urandom};
            endcase
            load_fail_limit(limit);
            set_idling(idle_kind_t'(p % 4));
            // fill the block up against a receiver that holds off
            if (p == 0) hold_kicks <= hold_kicks + 1;
            left = RANDOM_ITEMS / PHASES;
            while (left > 0) random_op(left);
        end

        // drain, then give stray results a chance to show up
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
